// ----- rtl/tcf_pkg.sv -----
// Shared constants, command types and the arctangent table for the tilt filter.
package tcf_pkg;

  localparam int CAL_SAMPLES  = 4096;
  localparam int CORDIC_ITERS = 20;
  localparam int SQRT_ITERS   = 30;
  localparam int DIV_CYCLES   = 10;   // five 16-bit quotient digits
  localparam int DEG90_Q16    = 5898240;
  localparam int STEP_DIVISOR = 1000; // ms to s
  localparam int BLEND_DIVISOR = 100;

  // Reciprocals for one quotient digit: exact for a digit dividend below divisor * 2^16
  localparam logic [26:0] STEP_RECIP        = 27'd68719477; // ceil(2^36 / 1000)
  localparam int          STEP_RECIP_SHIFT  = 36;
  localparam logic [26:0] BLEND_RECIP       = 27'd10737419; // ceil(2^30 / 100)
  localparam int          BLEND_RECIP_SHIFT = 30;

  // Configuration register indexes
  localparam logic [7:0] REG_GYRO_OFFSET = 8'd0;
  localparam logic [7:0] REG_NEGATE      = 8'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       sqrt_step;
    logic       cordic_init;
    logic       cordic_step;
    logic       accel_fin;
    logic       mul_lo;
    logic       mul_hi;
    logic       div_load_step;
    logic       div_step;
    logic       blend;
    logic       div_load_blend;
    logic       fuse_fin;
    logic       cal_fin;
    logic [5:0] iter;
  } tcf_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic out_full;
  } tcf_stat_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [22:0] atan_deg(input logic [4:0] i);
    logic [22:0] r;
    unique case (i)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tcf_ctrl.sv -----
// Sequencer for the tilt filter: steps the datapath through each request.
module tcf_ctrl import tcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      action,
  input  tcf_stat_t stat,
  output tcf_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQRT   = 4'd1;
  localparam logic [3:0] S_CINIT  = 4'd2;
  localparam logic [3:0] S_CORDIC = 4'd3;
  localparam logic [3:0] S_ACCEL  = 4'd4;
  localparam logic [3:0] S_MUL_LO = 4'd5;
  localparam logic [3:0] S_MUL_HI = 4'd6;
  localparam logic [3:0] S_DLOAD1 = 4'd7;
  localparam logic [3:0] S_DIV1   = 4'd8;
  localparam logic [3:0] S_BLEND  = 4'd9;
  localparam logic [3:0] S_DLOAD2 = 4'd10;
  localparam logic [3:0] S_DIV2   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       is_cal, is_cal_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !stat.out_full;

  // Next state, counter and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    is_cal_next = is_cal;
    cmd         = '0;
    cmd.iter    = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          is_cal_next = action;
          cnt_next    = '0;
          state_next  = action ? S_DONE : S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == 6'(SQRT_ITERS - 1)) begin
          cnt_next   = '0;
          state_next = S_CINIT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        state_next      = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (cnt == 6'(CORDIC_ITERS - 1)) begin
          cnt_next   = '0;
          state_next = S_ACCEL;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_ACCEL: begin
        cmd.accel_fin = 1'b1;
        state_next    = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_DLOAD1;
      end
      S_DLOAD1: begin
        cmd.div_load_step = 1'b1;
        state_next        = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (cnt == 6'(DIV_CYCLES - 1)) begin
          cnt_next   = '0;
          state_next = S_BLEND;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_DLOAD2;
      end
      S_DLOAD2: begin
        cmd.div_load_blend = 1'b1;
        state_next         = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (cnt == 6'(DIV_CYCLES - 1)) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.fuse_fin = !is_cal;
          cmd.cal_fin  = is_cal;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      is_cal <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      is_cal <= is_cal_next;
    end
  end

endmodule

// ----- rtl/tcf_datapath.sv -----
// Datapath: square root, CORDIC, gyro integration, blend, calibration, output register.
module tcf_datapath import tcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  tcf_cmd_t           cmd,
  output tcf_stat_t          stat,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [31:0] gyro_rate_x,
  input  logic [31:0]        timestamp_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_x,
  output logic signed [24:0] accel_angle,
  output logic signed [31:0] cal_offset,
  output logic               cal_done
);

  // configuration and filter state
  logic signed [31:0] gyro_offset;
  logic               negate_angle;
  logic signed [31:0] fused_angle;
  logic [31:0]        last_time;
  logic               time_seen;
  logic signed [44:0] cal_sum;
  logic [12:0]        cal_count;

  // per-request working registers
  logic signed [15:0] ay;
  logic signed [31:0] rate;
  logic [31:0]        ts;
  logic [32:0]        mag;
  logic               mag_neg;
  logic [31:0]        dt;
  logic [59:0]        sq_n, sq_res;
  logic signed [33:0] cx, cy;
  logic signed [24:0] cz;
  logic               x_zero;
  logic signed [24:0] acc;
  logic [64:0]        prod;
  logic [79:0]        dq;
  logic [9:0]         drem;
  logic               dsel_blend;
  logic [15:0]        dqd;
  logic signed [64:0] num;
  logic               num_neg;

  // load-time values
  logic [31:0]        sq_sum;
  logic signed [32:0] diff;
  always_comb begin
    sq_sum = 32'(32'(accel_x * accel_x) + 32'(accel_z * accel_z));
    diff   = 33'(gyro_rate_x) - 33'(gyro_offset);
  end

  // one square root step
  logic [59:0] sq_bit;
  logic [60:0] sq_t;
  always_comb begin
    sq_bit = 60'(1) << (7'd58 - {cmd.iter, 1'b0});
    sq_t   = 61'(sq_res) + 61'(sq_bit);
  end

  // one CORDIC vectoring step
  logic signed [33:0] cdx, cdy;
  logic signed [24:0] cat;
  always_comb begin
    cdx = cy >>> cmd.iter[4:0];
    cdy = cx >>> cmd.iter[4:0];
    cat = 25'(atan_deg(cmd.iter[4:0]));
  end

  // one 16-bit quotient digit: reciprocal estimate, then remainder
  logic [25:0] dv;
  logic [52:0] dprod;
  logic [15:0] dq_est;
  logic [25:0] dmul;
  logic [9:0]  drem_n;
  always_comb begin
    dv     = {drem, dq[79:64]};
    dprod  = 53'(dv) * 53'(dsel_blend ? BLEND_RECIP : STEP_RECIP);
    dq_est = dsel_blend ? 16'(dprod >> BLEND_RECIP_SHIFT) : 16'(dprod >> STEP_RECIP_SHIFT);
    dmul   = 26'(dqd) * (dsel_blend ? 26'(BLEND_DIVISOR) : 26'(STEP_DIVISOR));
    drem_n = 10'(dv - dmul);
  end

  // blend numerator: 98 * (angle + step) + 2 * accel angle
  logic [55:0]        stepmag;
  logic signed [56:0] step_s;
  logic signed [64:0] comb_w, acc_w, num_w;
  always_comb begin
    stepmag = dq[55:0];
    step_s  = mag_neg ? -$signed({1'b0, stepmag}) : $signed({1'b0, stepmag});
    comb_w  = 65'(fused_angle) + 65'(step_s);
    acc_w   = 65'(acc);
    num_w   = (comb_w <<< 6) + (comb_w <<< 5) + (comb_w <<< 1) + (acc_w <<< 1);
  end

  // rounded blend result, saturated
  logic [64:0]        num_mag;
  logic signed [59:0] qs;
  logic signed [31:0] fused_sat;
  always_comb begin
    num_mag = num_neg ? 65'(-num) : 65'(num);
    qs      = num_neg ? -$signed({1'b0, dq[58:0]}) : $signed({1'b0, dq[58:0]});
    if (qs > 60'sd2147483647)       fused_sat = 32'sh7fffffff;
    else if (qs < -60'sd2147483648) fused_sat = 32'sh80000000;
    else                            fused_sat = 32'(qs);
  end

  // calibration accumulate and mean
  logic signed [44:0] sum_n;
  logic [12:0]        cnt_n;
  logic [44:0]        sum_mag;
  logic [44:0]        mean_mag;
  logic signed [31:0] mean;
  always_comb begin
    sum_n    = cal_sum + 45'(rate);
    cnt_n    = cal_count + 13'd1;
    sum_mag  = sum_n[44] ? 45'(-sum_n) : 45'(sum_n);
    mean_mag = (sum_mag + 45'(CAL_SAMPLES / 2)) / CAL_SAMPLES;
    mean     = sum_n[44] ? 32'(-mean_mag) : 32'(mean_mag);
  end

  function automatic logic signed [31:0] report(input logic signed [31:0] a,
                                                input logic neg);
    logic signed [31:0] r;
    if (!neg)                    r = a;
    else if (a == 32'sh80000000) r = 32'sh7fffffff;
    else                         r = -a;
    return r;
  endfunction

  assign stat.out_full = out_valid && !out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_offset  <= '0;
      negate_angle <= 1'b0;
      fused_angle  <= '0;
      last_time    <= '0;
      time_seen    <= 1'b0;
      cal_sum      <= '0;
      cal_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_GYRO_OFFSET) gyro_offset <= cfg_data;
        if (cfg_index == REG_NEGATE)      negate_angle <= cfg_data[0];
      end
      if (cmd.fuse_fin) begin
        fused_angle <= fused_sat;
        last_time   <= ts;
        time_seen   <= 1'b1;
      end
      if (cmd.cal_fin) begin
        if (cnt_n >= 13'(CAL_SAMPLES)) begin
          cal_sum   <= '0;
          cal_count <= '0;
        end else begin
          cal_sum   <= sum_n;
          cal_count <= cnt_n;
        end
      end
      if (cmd.fuse_fin || cmd.cal_fin) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ay      <= accel_y;
      rate    <= gyro_rate_x;
      ts      <= timestamp_ms;
      mag     <= diff[32] ? 33'(-diff) : 33'(diff);
      mag_neg <= diff[32];
      dt      <= time_seen ? timestamp_ms - last_time : 32'd0;
      sq_n    <= {sq_sum, 28'd0};
      sq_res  <= '0;
    end
    if (cmd.sqrt_step) begin
      if (61'(sq_n) >= sq_t) begin
        sq_n   <= 60'(61'(sq_n) - sq_t);
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
    end
    if (cmd.cordic_init) begin
      cx     <= 34'(sq_res);
      cy     <= 34'(ay) <<< 14;
      cz     <= '0;
      x_zero <= (sq_res == '0);
    end
    if (cmd.cordic_step) begin
      if (cy < 0) begin
        cx <= cx - cdx;
        cy <= cy + cdy;
        cz <= cz - cat;
      end else begin
        cx <= cx + cdx;
        cy <= cy - cdy;
        cz <= cz + cat;
      end
    end
    if (cmd.accel_fin) begin
      priority if (ay == 0)                acc <= '0;
      else if (x_zero)                     acc <= (ay > 0) ? 25'sd5898240 : -25'sd5898240;
      else if (cz > 25'(DEG90_Q16))        acc <= 25'(DEG90_Q16);
      else if (cz < -25'(DEG90_Q16))       acc <= -25'(DEG90_Q16);
      else                                 acc <= cz;
    end
    if (cmd.mul_lo) prod <= 65'(mag * dt[15:0]);
    if (cmd.mul_hi) prod <= prod + (65'(mag * dt[31:16]) << 16);
    if (cmd.div_load_step) begin
      dq         <= {15'd0, prod};
      drem       <= '0;
      dsel_blend <= 1'b0;
    end
    // even cycle: estimate the digit, odd cycle: shift it in and keep the remainder
    if (cmd.div_step) begin
      if (!cmd.iter[0]) begin
        dqd <= dq_est;
      end else begin
        dq   <= {dq[63:0], dqd};
        drem <= drem_n;
      end
    end
    if (cmd.blend) begin
      num     <= num_w;
      num_neg <= num_w[64];
    end
    if (cmd.div_load_blend) begin
      dq         <= {15'd0, num_mag + 65'(BLEND_DIVISOR / 2)};
      drem       <= '0;
      dsel_blend <= 1'b1;
    end
    if (cmd.fuse_fin) begin
      angle_x     <= report(fused_sat, negate_angle);
      accel_angle <= acc;
      cal_offset  <= '0;
      cal_done    <= 1'b0;
    end
    if (cmd.cal_fin) begin
      angle_x     <= report(fused_angle, negate_angle);
      accel_angle <= '0;
      cal_offset  <= (cnt_n >= 13'(CAL_SAMPLES)) ? mean : 32'sd0;
      cal_done    <= (cnt_n >= 13'(CAL_SAMPLES));
    end
  end

endmodule

// ----- rtl/tilt_complementary_filter.sv -----
// Top level of the complementary-filter tilt estimator.
// Fuses accelerometer and gyro samples into a Q16.16 X tilt angle, or gathers
// gyro calibration samples. One request is worked at a time: a fuse request's
// result is written after 30 square-root steps, 20 CORDIC steps, a 33x16
// multiply over the low and high halves of dt, and two divisions, by 1000 and
// by 100, that form five 16-bit quotient digits by reciprocal multiplication,
// plus load and finish steps; a calibration request goes straight from load to
// its finish. The controller returns to idle as the result is written.
// A finished result sits in an output register, so the next request
// is accepted while it waits; a request only stalls at its finish while the
// previous result is still held.
// Configuration writes are taken every cycle (cfg_ready is always high);
// index 0 is gyro_offset, index 1 is negate_angle, others are ignored.
module tilt_complementary_filter import tcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [31:0] gyro_rate_x,
  input  logic [31:0]        timestamp_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] angle_x,
  output logic signed [24:0] accel_angle,
  output logic signed [31:0] cal_offset,
  output logic               cal_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  tcf_cmd_t  cmd;
  tcf_stat_t stat;

  assign cfg_ready = 1'b1;

  tcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .gyro_rate_x  (gyro_rate_x),
    .timestamp_ms (timestamp_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .angle_x      (angle_x),
    .accel_angle  (accel_angle),
    .cal_offset   (cal_offset),
    .cal_done     (cal_done)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the complementary-filter tilt estimator.
`timescale 1ns / 100ps

module testbench;
  import tcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;

  typedef struct {
    logic        action;
    logic [15:0] ax, ay, az;
    logic [31:0] rate;
    logic [31:0] ts;
  } imu_req_t;

  typedef struct {
    logic [31:0] angle;
    logic [24:0] acc;
    logic [31:0] cal;
    logic        done;
  } tilt_res_t;

  typedef struct {
    logic [7:0]  idx;
    logic [31:0] data;
  } cfg_req_t;

  logic clk, rst;
  logic in_valid, in_ready, action;
  logic signed [15:0] accel_x, accel_y, accel_z;
  logic signed [31:0] gyro_rate_x;
  logic [31:0] timestamp_ms;
  logic out_valid, out_ready;
  logic signed [31:0] angle_x, cal_offset;
  logic signed [24:0] accel_angle;
  logic cal_done;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [31:0] cfg_data;

  tilt_complementary_filter u_top (.*);

  // predictor state
  longint    m_offset;
  bit        m_negate;
  longint    m_angle;
  bit [31:0] m_last_time;
  bit        m_time_seen;
  longint    m_cal_sum;
  int        m_cal_count;

  imu_req_t  pending_reqs[$];
  cfg_req_t  pending_cfgs[$];
  tilt_res_t expected_results[$];
  int        fail_count;
  int        idle_cycles;
  bit        in_taken;
  int        burst_left, gap_left;
  logic [31:0] ts_now;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  // accelerometer tilt by CORDIC vectoring
  function automatic longint tilt_of_accel(longint ax, longint ay, longint az);
    longint x, y, z, dx, dy;
    longint tbl[20];
    tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    if (ay == 0) return 0;
    x = int_sqrt(longint'(ax * ax + az * az) << 28);
    if (x == 0) return (ay > 0) ? DEG90_Q16 : -DEG90_Q16;
    y = ay * 16384;
    z = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= tbl[i];
      end else begin
        x += dx; y -= dy; z += tbl[i];
      end
    end
    if (z > DEG90_Q16) z = DEG90_Q16;
    if (z < -DEG90_Q16) z = -DEG90_Q16;
    return z;
  endfunction

  function automatic tilt_res_t predict_tilt(imu_req_t r);
    tilt_res_t res;
    longint rate, acc, diff, mag, stp;
    longint unsigned stpmag;
    bit [31:0] dt;
    rate = longint'(signed'(r.rate));
    res.acc = '0;
    res.cal = '0;
    res.done = 1'b0;
    if (!r.action) begin
      acc = tilt_of_accel(longint'(signed'(r.ax)), longint'(signed'(r.ay)),
                          longint'(signed'(r.az)));
      diff = rate - m_offset;
      dt = m_time_seen ? r.ts - m_last_time : 32'd0;
      mag = (diff < 0) ? -diff : diff;
      // product can exceed 2^63, so keep it unsigned
      stpmag = (64'(mag) * 64'(dt)) / 64'd1000;
      stp = longint'(stpmag);
      if (diff < 0) stp = -stp;
      m_angle = sat_s32(round_div(98 * (m_angle + stp) + 2 * acc, 100));
      m_last_time = r.ts;
      m_time_seen = 1'b1;
      res.acc = acc[24:0];
    end else begin
      m_cal_sum += rate;
      m_cal_count++;
      if (m_cal_count >= CAL_SAMPLES) begin
        res.cal = 32'(round_div(m_cal_sum, CAL_SAMPLES));
        res.done = 1'b1;
        m_cal_sum = 0;
        m_cal_count = 0;
      end
    end
    if (m_negate)
      res.angle = (m_angle == -64'sd2147483648) ? 32'h7fffffff : 32'(-m_angle);
    else
      res.angle = 32'(m_angle);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // request driver: bursts and gaps, changes on falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_taken = 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        action <= pending_reqs[0].action;
        accel_x <= pending_reqs[0].ax;
        accel_y <= pending_reqs[0].ay;
        accel_z <= pending_reqs[0].az;
        gyro_rate_x <= pending_reqs[0].rate;
        timestamp_ms <= pending_reqs[0].ts;
        void'(pending_reqs.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall pattern and config driver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 7);
      if (!cfg_valid || cfg_ready) begin
        if (pending_cfgs.size() > 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= pending_cfgs[0].idx;
          cfg_data <= pending_cfgs[0].data;
          void'(pending_cfgs.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin
    tilt_res_t want;
    bit        progress;
    if (!rst) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GYRO_OFFSET) m_offset = longint'(signed'(cfg_data));
        else if (cfg_index == REG_NEGATE) m_negate = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_tilt('{action, accel_x, accel_y,
                                                  accel_z, gyro_rate_x, timestamp_ms}));
        in_taken = 1'b1;
        progress = 1'b1;
      end
      if (out_valid && out_ready) begin
        progress = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", angle_x, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (angle_x !== want.angle) report_mismatch("angle_x", angle_x, want.angle);
          if (accel_angle !== want.acc)
            report_mismatch("accel_angle", 32'(accel_angle), 32'(want.acc));
          if (cal_offset !== want.cal) report_mismatch("cal_offset", cal_offset, want.cal);
          if (cal_done !== want.done)
            report_mismatch("cal_done", 32'(cal_done), 32'(want.done));
        end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_req(bit act, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                          logic [31:0] rate, logic [31:0] ts);
    pending_reqs.push_back('{act, ax, ay, az, rate, ts});
  endtask

  task automatic push_fuse_rand();
    logic [15:0] ax, ay, az;
    ts_now += (($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40));
    ax = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
    ay = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
    az = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
    if ($urandom_range(0, 15) == 0) ay = 16'd0;
    if ($urandom_range(0, 15) == 0) begin ax = 16'd0; az = 16'd0; end
    push_req(1'b0, ax, ay, az,
             ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000),
             ts_now);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || pending_cfgs.size() > 0 || in_valid || cfg_valid ||
           expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [31:0] data);
    pending_cfgs.push_back('{idx, data});
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; out_ready = 1'b0; cfg_valid = 1'b0;
    action = 1'b0; accel_x = '0; accel_y = '0; accel_z = '0;
    gyro_rate_x = '0; timestamp_ms = '0; cfg_index = '0; cfg_data = '0;
    m_offset = 0; m_negate = 0; m_angle = 0; m_last_time = 0; m_time_seen = 0;
    m_cal_sum = 0; m_cal_count = 0;
    fail_count = 0; idle_cycles = 0; in_taken = 0;
    burst_left = 0; gap_left = 0; ts_now = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: first sample, zero Y, zero horizontal, extremes
    push_req(1'b0, 16'd100, 16'd200, 16'd300, 32'h7fffffff, 32'hfffffff0);
    push_req(1'b0, 16'd0, 16'd0, 16'd0, 32'h0, 32'h00000010);
    push_req(1'b0, 16'd0, 16'h7fff, 16'd0, 32'h80000000, 32'h00000020);
    push_req(1'b0, 16'd0, 16'h8000, 16'd0, 32'h1000, 32'h00000030);
    push_req(1'b0, 16'h8000, 16'h8000, 16'h8000, 32'h7fffffff, 32'h80000030);
    push_req(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff, 32'hffffffff);
    push_req(1'b0, 16'h8000, 16'h0001, 16'h7fff, 32'h80000000, 32'h7fffffff);
    push_req(1'b0, 16'h0001, 16'hffff, 16'h0000, 32'h80000000, 32'hfffffffe);
    push_req(1'b1, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff);
    push_req(1'b1, 16'h0, 16'h0, 16'h0, 32'h80000000, 32'h0);
    wait_drained();
    write_cfg(REG_NEGATE, 32'd1);
    write_cfg(REG_GYRO_OFFSET, 32'h80000000);
    write_cfg(8'd7, 32'hffffffff);
    wait_drained();
    // drive stored angle toward -90 degrees by the accelerometer, then read it negated
    for (int i = 0; i < 6; i++)
      push_req(1'b0, 16'd0, 16'h8000, 16'd0, 32'h80000000, 32'hfffffff0 + 32'(i) * 32'h40000000);
    push_req(1'b1, 16'd0, 16'd0, 16'd0, 32'h7fffffff, 32'd0);
    wait_drained();

    // random phases with varying configuration
    for (int phase = 0; phase < 6; phase++) begin
      write_cfg(REG_NEGATE, 32'($urandom_range(0, 1)));
      case (phase)
        0: write_cfg(REG_GYRO_OFFSET, 32'h7fffffff);
        1: write_cfg(REG_GYRO_OFFSET, 32'h0);
        default: write_cfg(REG_GYRO_OFFSET, $urandom);
      endcase
      wait_drained();
      for (int i = 0; i < 215; i++) begin
        if ($urandom_range(0, 9) == 0)
          push_req(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom);
        else
          push_fuse_rand();
      end
      wait_drained();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tcf_pkg.sv
rtl/tcf_ctrl.sv
rtl/tcf_datapath.sv
rtl/tilt_complementary_filter.sv
tb/sv/testbench.sv
